FILE: rtl/wmt_pkg.sv
// Shared constants for the window mode tracker.
package wmt_pkg;
  localparam int unsigned TYPE_W = 8;
  localparam int unsigned TOP_TYPE_W = 7;
  localparam int unsigned TOP_COUNT_W = 6;
  localparam int unsigned DISTINCT_W = 8;
endpackage

FILE: rtl/window_mode_tracker.sv
// Window mode tracker: sliding-window type counts with a ranked mode list.
//
// Usage: one request on the in_ channel carries a packet payload type. Each
// request gives exactly one result on the out_ channel: whether the type was
// counted, the head of the ranked list with its window count, and the number
// of distinct types seen. Types at or above TYPES are reported but not counted.
// The block works on one request at a time; in_ready is high only while idle.
// From the accepting edge to the registered result: an ignored type goes
// straight to the head read, and a type that already sits in its own slot
// goes there after the slot check; otherwise the slot and count update come
// first, then a bubbling pass that moves the new type past its neighbours,
// a second pass for the replaced type when the slot was occupied, and the
// head read. The next request can be taken in the cycle after the result is
// registered.
// Reset clears the window valid bits, ranked bits, the list length and the
// window pointer; the memories need no clearing pass because only entries below
// the list length or with a ranked bit are ever used.
// When the receiver stalls, the result holds on the out_ ports and the next
// request waits in the final state until the result is taken.
module window_mode_tracker #(
  parameter int unsigned WINDOW = 32,
  parameter int unsigned TYPES = 128
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  logic [wmt_pkg::TYPE_W-1:0] in_payload_type,
  output logic out_valid,
  input  logic out_ready,
  output logic out_accepted,
  output logic out_top_valid,
  output logic [wmt_pkg::TOP_TYPE_W-1:0] out_top_type,
  output logic [wmt_pkg::TOP_COUNT_W-1:0] out_top_count,
  output logic [wmt_pkg::DISTINCT_W-1:0] out_distinct_types
);
  localparam int unsigned WP_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned TI_W = (TYPES > 1) ? $clog2(TYPES) : 1;
  localparam int unsigned LEN_W = $clog2(TYPES + 1);
  localparam int unsigned CNT_W = $clog2(WINDOW + 1);
  localparam int unsigned TT_W = wmt_pkg::TOP_TYPE_W;
  localparam int unsigned TC_W = wmt_pkg::TOP_COUNT_W;
  localparam int unsigned DT_W = wmt_pkg::DISTINCT_W;

  typedef enum logic [3:0] {
    S_IDLE, S_SLOT, S_OTW, S_UPRD, S_UPCNT, S_UPCHK, S_DNRD, S_DNCNT, S_DNCHK,
    S_FIN, S_OTPOS, S_HRD, S_HCNT, S_DONE
  } state_t;

  // Memories: ranked list (position -> type), position table, counts, window slots.
  logic [TI_W-1:0] rank_mem [TYPES];
  logic [TI_W-1:0] pos_mem [TYPES];
  logic [CNT_W-1:0] cnt_mem [TYPES];
  logic [TI_W-1:0] slot_mem [WINDOW];
  logic [WINDOW-1:0] slot_vld_r;
  logic [TYPES-1:0] ranked_r;

  state_t state_r;
  logic [TI_W-1:0] nt_r, ot_r, ty_r, other_r;
  logic had_r, second_r, moved_r, newly_r, acc_r;
  logic [TI_W-1:0] p_r;
  logic [CNT_W-1:0] c_r, cnt_ot_r;
  logic [WP_W-1:0] wp_r;
  logic [LEN_W-1:0] len_r;
  logic [TI_W-1:0] head_r;
  logic [TI_W-1:0] slot_rd_r, rank_rd_r, pos_rd_r;
  logic [CNT_W-1:0] cnt_rd_r;
  logic out_valid_r, out_acc_r, out_top_valid_r;
  logic [TT_W-1:0] out_top_type_r;
  logic [TC_W-1:0] out_top_count_r;
  logic [DT_W-1:0] out_distinct_r;

  // One write port and one read port per memory, driven by the sequencer.
  logic rank_we, pos_we, cnt_we, slot_we;
  logic [TI_W-1:0] rank_wa, rank_wd, rank_ra, pos_wa, pos_wd, pos_ra, cnt_wa, cnt_ra;
  logic [CNT_W-1:0] cnt_wd;

  logic in_known, same_slot, take_new;
  logic [CNT_W-1:0] cnt_nt_new, cnt_ot_dec;
  logic [WP_W-1:0] wp_nxt;

  assign in_known = 32'(in_payload_type) < TYPES;
  assign same_slot = slot_vld_r[wp_r] && (slot_rd_r == nt_r);
  assign take_new = !ranked_r[nt_r] && (32'(len_r) < TYPES);
  // An unranked type has never been counted, so its stale memory word is replaced by zero.
  assign cnt_nt_new = (ranked_r[nt_r] ? cnt_rd_r : '0) + CNT_W'(1);
  assign cnt_ot_dec = (cnt_rd_r != '0) ? cnt_rd_r - CNT_W'(1) : cnt_rd_r;
  assign wp_nxt = (32'(wp_r) == WINDOW - 1) ? '0 : wp_r + WP_W'(1);

  assign in_ready = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_accepted = out_acc_r;
  assign out_top_valid = out_top_valid_r;
  assign out_top_type = out_top_type_r;
  assign out_top_count = out_top_count_r;
  assign out_distinct_types = out_distinct_r;

  always_ff @(posedge clk) begin
    if (rank_we) rank_mem[rank_wa] <= rank_wd;
    rank_rd_r <= rank_mem[rank_ra];
    if (pos_we) pos_mem[pos_wa] <= pos_wd;
    pos_rd_r <= pos_mem[pos_ra];
    if (cnt_we) cnt_mem[cnt_wa] <= cnt_wd;
    cnt_rd_r <= cnt_mem[cnt_ra];
    if (slot_we) slot_mem[wp_r] <= nt_r;
    slot_rd_r <= slot_mem[wp_r];
  end

  always_comb begin
    rank_we = 1'b0;
    rank_wa = p_r;
    rank_wd = other_r;
    rank_ra = p_r;
    pos_we = 1'b0;
    pos_wa = other_r;
    pos_wd = p_r;
    pos_ra = nt_r;
    cnt_we = 1'b0;
    cnt_wa = nt_r;
    cnt_wd = cnt_nt_new;
    cnt_ra = head_r;
    slot_we = 1'b0;
    case (state_r)
      S_IDLE: cnt_ra = in_payload_type[TI_W-1:0];
      S_SLOT: begin
        cnt_ra = slot_rd_r;
        if (!same_slot) begin
          slot_we = 1'b1;
          cnt_we = 1'b1;
        end
      end
      S_OTW: begin
        cnt_we = had_r;
        cnt_wa = ot_r;
        cnt_wd = cnt_ot_dec;
      end
      S_UPRD: rank_ra = p_r - TI_W'(1);
      S_UPCNT, S_DNCNT: cnt_ra = rank_rd_r;
      S_UPCHK: begin
        // The moving type floats; only the passed entry is written back.
        if (cnt_rd_r < c_r) begin
          rank_we = 1'b1;
          pos_we = 1'b1;
        end
      end
      S_DNRD: rank_ra = p_r + TI_W'(1);
      S_DNCHK: begin
        if (cnt_rd_r > c_r) begin
          rank_we = 1'b1;
          pos_we = 1'b1;
        end
      end
      S_FIN: begin
        rank_we = 1'b1;
        rank_wd = ty_r;
        pos_we = 1'b1;
        pos_wa = ty_r;
        pos_ra = ot_r;
      end
      S_HRD: rank_ra = '0;
      S_HCNT: cnt_ra = rank_rd_r;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      slot_vld_r <= '0;
      ranked_r <= '0;
      wp_r <= '0;
      len_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_DONE && (!out_valid_r || out_ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            nt_r <= in_payload_type[TI_W-1:0];
            acc_r <= in_known;
            state_r <= in_known ? S_SLOT : S_HRD;
          end
        end
        S_SLOT: begin
          ot_r <= slot_rd_r;
          had_r <= slot_vld_r[wp_r];
          wp_r <= wp_nxt;
          if (same_slot) begin
            state_r <= S_HRD;
          end else begin
            slot_vld_r[wp_r] <= 1'b1;
            c_r <= cnt_nt_new;
            newly_r <= take_new;
            p_r <= len_r[TI_W-1:0];
            if (take_new) begin
              ranked_r[nt_r] <= 1'b1;
              len_r <= len_r + LEN_W'(1);
            end
            state_r <= S_OTW;
          end
        end
        S_OTW: begin
          cnt_ot_r <= cnt_ot_dec;
          if (!newly_r) p_r <= pos_rd_r;
          ty_r <= nt_r;
          second_r <= 1'b0;
          moved_r <= 1'b0;
          state_r <= S_UPRD;
        end
        S_UPRD: state_r <= (p_r == '0) ? S_DNRD : S_UPCNT;
        S_UPCNT: begin
          other_r <= rank_rd_r;
          state_r <= S_UPCHK;
        end
        S_UPCHK: begin
          if (cnt_rd_r < c_r) begin
            p_r <= p_r - TI_W'(1);
            moved_r <= 1'b1;
            state_r <= S_UPRD;
          end else begin
            // After moving up, the entry below has a lower count: no down pass.
            state_r <= moved_r ? S_FIN : S_DNRD;
          end
        end
        S_DNRD: begin
          if (LEN_W'(p_r) + LEN_W'(1) >= len_r) begin
            state_r <= S_FIN;
          end else begin
            state_r <= S_DNCNT;
          end
        end
        S_DNCNT: begin
          other_r <= rank_rd_r;
          state_r <= S_DNCHK;
        end
        S_DNCHK: begin
          if (cnt_rd_r > c_r) begin
            p_r <= p_r + TI_W'(1);
            state_r <= S_DNRD;
          end else begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!second_r && had_r) begin
            second_r <= 1'b1;
            state_r <= S_OTPOS;
          end else begin
            state_r <= S_HRD;
          end
        end
        S_OTPOS: begin
          p_r <= pos_rd_r;
          ty_r <= ot_r;
          c_r <= cnt_ot_r;
          moved_r <= 1'b0;
          state_r <= S_UPRD;
        end
        S_HRD: state_r <= S_HCNT;
        S_HCNT: begin
          head_r <= rank_rd_r;
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_acc_r <= acc_r;
            out_top_valid_r <= (len_r != '0);
            out_top_type_r <= (len_r != '0) ? TT_W'(head_r) : '0;
            out_top_count_r <= (len_r != '0) ? TC_W'(cnt_rd_r) : '0;
            out_distinct_r <= DT_W'(len_r);
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_accepted)
      && $stable(out_top_valid) && $stable(out_top_type) && $stable(out_top_count)
      && $stable(out_distinct_types));
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready);
  a_len_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(len_r) <= TYPES);
  a_wp_range: assert property (@(posedge clk) disable iff (!rst_n)
    32'(wp_r) < WINDOW);
  a_head_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_top_valid == (out_distinct_types != '0)));
endmodule

FILE: dv/tb_top.sv
// Self-checking testbench for the window mode tracker.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN = 32;
  localparam int NTYPES = 128;
  localparam longint CYCLE_LIMIT = 5000000;

  typedef struct packed {
    logic                            accepted;
    logic                            top_valid;
    logic [wmt_pkg::TOP_TYPE_W-1:0]  top_type;
    logic [wmt_pkg::TOP_COUNT_W-1:0] top_count;
    logic [wmt_pkg::DISTINCT_W-1:0]  distinct_types;
  } mode_report_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [wmt_pkg::TYPE_W-1:0] in_payload_type = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic out_accepted;
  logic out_top_valid;
  logic [wmt_pkg::TOP_TYPE_W-1:0] out_top_type;
  logic [wmt_pkg::TOP_COUNT_W-1:0] out_top_count;
  logic [wmt_pkg::DISTINCT_W-1:0] out_distinct_types;

  window_mode_tracker dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_payload_type(in_payload_type),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_accepted(out_accepted), .out_top_valid(out_top_valid),
    .out_top_type(out_top_type), .out_top_count(out_top_count),
    .out_distinct_types(out_distinct_types)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Tracker shadow state.
  logic [6:0] win_type [WIN];
  bit         win_full [WIN];
  int         type_cnt [NTYPES];
  int         rank_of [NTYPES];
  bit         is_ranked [NTYPES];
  logic [6:0] rank_list [NTYPES];
  int         list_len;
  int         win_ptr;

  mode_report_t pending_reports[$];
  int mismatches = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_cycles = 0;
  longint cycle_count = 0;

  function automatic void swap_rank(int a, int b);
    logic [6:0] ta;
    logic [6:0] tb;
    ta = rank_list[a];
    tb = rank_list[b];
    rank_list[a] = tb;
    rank_list[b] = ta;
    rank_of[ta] = b;
    rank_of[tb] = a;
  endfunction

  function automatic void bubble(logic [6:0] ty);
    int p;
    if (!is_ranked[ty]) return;
    p = rank_of[ty];
    while (p > 0 && p < list_len && type_cnt[rank_list[p-1]] < type_cnt[ty]) begin
      swap_rank(p - 1, p);
      p--;
    end
    while (p + 1 < list_len && type_cnt[rank_list[p+1]] > type_cnt[ty]) begin
      swap_rank(p, p + 1);
      p++;
    end
  endfunction

  function automatic void clear_tracker();
    for (int i = 0; i < WIN; i++) begin
      win_full[i] = 1'b0;
      win_type[i] = '0;
    end
    for (int i = 0; i < NTYPES; i++) begin
      type_cnt[i] = 0;
      is_ranked[i] = 1'b0;
      rank_of[i] = 0;
      rank_list[i] = '0;
    end
    list_len = 0;
    win_ptr = 0;
  endfunction

  function automatic mode_report_t track_type(logic [7:0] pt);
    mode_report_t r;
    logic [6:0] nt;
    logic [6:0] ot;
    bit had_old;
    r = '0;
    if (pt < NTYPES) begin
      nt = pt[6:0];
      had_old = win_full[win_ptr];
      ot = win_type[win_ptr];
      r.accepted = 1'b1;
      if (!(had_old && ot == nt)) begin
        if (had_old && type_cnt[ot] > 0) type_cnt[ot]--;
        win_type[win_ptr] = nt;
        win_full[win_ptr] = 1'b1;
        type_cnt[nt]++;
        if (!is_ranked[nt] && list_len < NTYPES) begin
          is_ranked[nt] = 1'b1;
          rank_of[nt] = list_len;
          rank_list[list_len] = nt;
          list_len++;
        end
        bubble(nt);
        if (had_old) bubble(ot);
      end
      win_ptr = (win_ptr + 1) % WIN;
    end
    if (list_len > 0) begin
      r.top_valid = 1'b1;
      r.top_type = rank_list[0];
      r.top_count = type_cnt[rank_list[0]][wmt_pkg::TOP_COUNT_W-1:0];
    end
    r.distinct_types = list_len[wmt_pkg::DISTINCT_W-1:0];
    return r;
  endfunction

  task automatic send_type(logic [7:0] pt);
    while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_payload_type <= pt;
    do @(posedge clk); while (!in_ready);
    pending_reports.push_back(track_type(pt));
  endtask

  // Receiver: random stalls, plus a long hold-off when hold_cycles is set.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    mode_report_t got;
    mode_report_t want;
    if (rst_n && out_valid && out_ready) begin
      got = {out_accepted, out_top_valid, out_top_type, out_top_count,
             out_distinct_types};
      if (pending_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
      end else begin
        want = pending_reports.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: acc %b/%b tv %b/%b type %0d/%0d cnt %0d/%0d dist %0d/%0d",
                     want.accepted, got.accepted, want.top_valid, got.top_valid,
                     want.top_type, got.top_type, want.top_count, got.top_count,
                     want.distinct_types, got.distinct_types);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_type(8'd200);
    send_type(8'd128);
    send_type(8'd255);
    send_type(8'd0);
    send_type(8'd127);
    send_type(8'd127);
    send_type(8'd0);
    send_type(8'd127);
    for (int i = 0; i < 30; i++) send_type(8'd5);
    send_type(8'd5);
    for (int i = 0; i < 33; i++) send_type(8'd9);
    send_type(8'd255);
    send_type(8'hAA);
    send_type(8'h55);
    wait_drained();
  endtask

  // Mostly a few popular types so counts climb and the list reorders.
  function automatic logic [7:0] pick_type();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) return 8'($urandom_range(255, 128));
    if (sel < 65) return 8'($urandom_range(5));
    if (sel < 85) return 8'($urandom_range(20));
    return 8'($urandom_range(127));
  endfunction

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) send_type(pick_type());
    wait_drained();
  endtask

  task automatic test_backpressure();
    hold_cycles = 300;
    for (int i = 0; i < 20; i++) send_type(pick_type());
    wait_drained();
  endtask

  initial begin
    clear_tracker();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    send_idle_pct = 34;
    recv_idle_pct = 82;
    test_random(450);
    test_backpressure();
    send_idle_pct = 82;
    recv_idle_pct = 34;
    test_random(450);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(450);
    repeat (200) @(posedge clk);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule

FILE: files.f
rtl/wmt_pkg.sv
rtl/window_mode_tracker.sv
dv/tb_top.sv
